FILE: rtl/core/sjf_pkg.sv
package sjf_pkg;

  localparam int BURST_W  = 16;
  localparam int JOB_ID_W = 5;
  localparam int TIME_W   = 20;
  localparam int AVG_W    = 28;
  localparam int AVG_FRAC = 8;

  typedef logic [BURST_W-1:0]  burst_t;
  typedef logic [JOB_ID_W-1:0] job_id_t;
  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [AVG_W-1:0]    avg_t;

  typedef struct packed {
    burst_t burst_time;
    logic   last;
  } sjf_in_t;

  typedef struct packed {
    job_id_t job_id;
    burst_t  burst;
    time_t   wait_time;
    time_t   turnaround_time;
    avg_t    avg_wait_q8;
    avg_t    avg_turnaround_q8;
    logic    end_of_set;
    logic    dropped;
  } sjf_out_t;

  typedef struct packed {
    job_id_t id;
    burst_t  burst;
  } entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_SCAN,
    ST_SWAP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic scan;
    logic swap;
    logic div_start;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic last_pass;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/core/sjf_div.sv
module sjf_div #(
  parameter int DIVD_W = 34,
  parameter int DIVS_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              busy,
  output logic [DIVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dsr;
  logic [STEP_W-1:0] steps;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              take;

  assign trial = {rem, quotient[DIVD_W-1]};
  assign take  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(DIVD_W);
    end else if (busy) begin
      steps <= steps - STEP_W'(1);
      busy  <= steps != STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= take ? DIVS_W'(diff) : DIVS_W'(trial);
      quotient <= {quotient[DIVD_W-2:0], take};
    end
  end

endmodule

FILE: rtl/core/sjf_ctrl.sv
module sjf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  logic             job_last,
  input  sjf_pkg::status_t status,
  output logic             job_ready,
  output sjf_pkg::cmd_t    cmd
);

  sjf_pkg::state_t state;
  sjf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sjf_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sjf_pkg::ST_LOAD: begin
        if (job_valid && job_last) state_next = sjf_pkg::ST_READ;
      end
      sjf_pkg::ST_READ: begin
        state_next = sjf_pkg::ST_SCAN;
      end
      sjf_pkg::ST_SCAN: begin
        if (status.scan_done) state_next = sjf_pkg::ST_SWAP;
      end
      sjf_pkg::ST_SWAP: begin
        state_next = status.last_pass ? sjf_pkg::ST_DIV_GO : sjf_pkg::ST_PUSH;
      end
      sjf_pkg::ST_DIV_GO: begin
        state_next = sjf_pkg::ST_DIV_WAIT;
      end
      sjf_pkg::ST_DIV_WAIT: begin
        if (!status.div_busy) state_next = sjf_pkg::ST_PUSH;
      end
      sjf_pkg::ST_PUSH: begin
        if (status.out_free) begin
          state_next = status.last_pass ? sjf_pkg::ST_LOAD : sjf_pkg::ST_READ;
        end
      end
      default: begin
        state_next = sjf_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    job_ready = 1'b0;
    case (state)
      sjf_pkg::ST_LOAD: begin
        job_ready = 1'b1;
        cmd.load  = job_valid;
      end
      sjf_pkg::ST_READ: begin
        cmd.read = 1'b1;
      end
      sjf_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      sjf_pkg::ST_SWAP: begin
        cmd.swap = 1'b1;
      end
      sjf_pkg::ST_DIV_GO: begin
        cmd.div_start = 1'b1;
      end
      sjf_pkg::ST_PUSH: begin
        cmd.push = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/core/sjf_dpath.sv
module sjf_dpath #(
  parameter int MAX_JOBS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  sjf_pkg::cmd_t     cmd,
  input  sjf_pkg::sjf_in_t  job_data,
  input  logic              sched_ready,
  output sjf_pkg::status_t  status,
  output logic              sched_valid,
  output sjf_pkg::sjf_out_t sched_data
);

  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int ELAP_W = sjf_pkg::BURST_W + CNT_W;
  localparam int SUM_W  = sjf_pkg::BURST_W + 2 * CNT_W;
  localparam int DIVD_W = SUM_W + sjf_pkg::AVG_FRAC;
  localparam int TSAT_W = (ELAP_W > sjf_pkg::TIME_W) ? ELAP_W : sjf_pkg::TIME_W;
  localparam int QSAT_W = (DIVD_W > sjf_pkg::AVG_W) ? DIVD_W : sjf_pkg::AVG_W;
  localparam logic [TSAT_W-1:0] TimeMax = TSAT_W'((64'd1 << sjf_pkg::TIME_W) - 64'd1);
  localparam logic [QSAT_W-1:0] AvgMax  = QSAT_W'((64'd1 << sjf_pkg::AVG_W) - 64'd1);

  sjf_pkg::entry_t mem [MAX_JOBS];
  sjf_pkg::entry_t mem_q;
  sjf_pkg::entry_t mem_wdata;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic             mem_re;

  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [IDX_W-1:0]  a;
  logic [CNT_W-1:0]  b;
  logic [IDX_W-1:0]  sel;
  logic              q_vld;
  logic [IDX_W-1:0]  q_idx;
  sjf_pkg::entry_t   min_ent;
  sjf_pkg::entry_t   a_ent;
  logic [ELAP_W-1:0] elapsed;
  logic [SUM_W-1:0]  sum_wait;
  logic [SUM_W-1:0]  sum_tat;
  sjf_pkg::job_id_t  res_id;
  sjf_pkg::burst_t   res_burst;
  sjf_pkg::time_t    res_wait;
  sjf_pkg::time_t    res_tat;

  logic              store_ok;
  logic [ELAP_W-1:0] tat;
  logic [TSAT_W-1:0] wait_ext;
  logic [TSAT_W-1:0] tat_ext;
  logic              issue;
  logic              div_busy_w;
  logic              div_busy_t;
  logic [DIVD_W-1:0] quo_w;
  logic [DIVD_W-1:0] quo_t;
  logic [QSAT_W-1:0] quo_w_ext;
  logic [QSAT_W-1:0] quo_t_ext;
  sjf_pkg::avg_t     avg_w;
  sjf_pkg::avg_t     avg_t;

  assign store_ok = count < CNT_W'(MAX_JOBS);
  assign issue    = cmd.scan && (b < count);
  assign tat      = elapsed + ELAP_W'(min_ent.burst);
  assign wait_ext = TSAT_W'(elapsed);
  assign tat_ext  = TSAT_W'(tat);
  assign quo_w_ext = QSAT_W'(quo_w);
  assign quo_t_ext = QSAT_W'(quo_t);
  assign avg_w = (quo_w_ext > AvgMax) ? sjf_pkg::avg_t'(AvgMax) : sjf_pkg::avg_t'(quo_w_ext);
  assign avg_t = (quo_t_ext > AvgMax) ? sjf_pkg::avg_t'(AvgMax) : sjf_pkg::avg_t'(quo_t_ext);

  assign status.scan_done = !q_vld && (b >= count);
  assign status.last_pass = (CNT_W'(a) + CNT_W'(1)) == count;
  assign status.div_busy  = div_busy_w || div_busy_t;
  assign status.out_free  = !sched_valid || sched_ready;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sel;
    mem_wdata = a_ent;
    if (cmd.load && store_ok) begin
      mem_we          = 1'b1;
      mem_waddr       = count[IDX_W-1:0];
      mem_wdata.id    = sjf_pkg::job_id_t'(32'(count) + 32'd1);
      mem_wdata.burst = job_data.burst_time;
    end else if (cmd.swap) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    mem_re    = cmd.read || issue;
    mem_raddr = cmd.read ? a : b[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      q_vld <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (store_ok) begin
          count <= count + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.push && status.last_pass) begin
        count <= '0;
        ovf   <= 1'b0;
      end
      if (cmd.read) begin
        q_vld <= 1'b1;
      end else if (cmd.scan) begin
        q_vld <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && job_data.last) begin
      a        <= '0;
      elapsed  <= '0;
      sum_wait <= '0;
      sum_tat  <= '0;
    end
    if (cmd.read) begin
      q_idx <= a;
      b     <= CNT_W'(a) + CNT_W'(1);
    end
    if (cmd.scan) begin
      if (q_vld) begin
        if (q_idx == a) begin
          min_ent <= mem_q;
          a_ent   <= mem_q;
          sel     <= a;
        end else if (mem_q.burst < min_ent.burst) begin
          min_ent <= mem_q;
          sel     <= q_idx;
        end
      end
      if (issue) begin
        q_idx <= b[IDX_W-1:0];
        b     <= b + CNT_W'(1);
      end
    end
    if (cmd.swap) begin
      res_id    <= min_ent.id;
      res_burst <= min_ent.burst;
      res_wait  <= (wait_ext > TimeMax) ? sjf_pkg::time_t'(TimeMax)
                                        : sjf_pkg::time_t'(wait_ext);
      res_tat   <= (tat_ext > TimeMax) ? sjf_pkg::time_t'(TimeMax)
                                       : sjf_pkg::time_t'(tat_ext);
      elapsed   <= tat;
      sum_wait  <= sum_wait + SUM_W'(elapsed);
      sum_tat   <= sum_tat + SUM_W'(tat);
    end
    if (cmd.push && !status.last_pass) begin
      a <= a + IDX_W'(1);
    end
  end

  sjf_div #(
    .DIVD_W(DIVD_W),
    .DIVS_W(CNT_W)
  ) u_div_wait (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({sum_wait, {sjf_pkg::AVG_FRAC{1'b0}}}),
    .divisor  (count),
    .busy     (div_busy_w),
    .quotient (quo_w)
  );

  sjf_div #(
    .DIVD_W(DIVD_W),
    .DIVS_W(CNT_W)
  ) u_div_tat (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({sum_tat, {sjf_pkg::AVG_FRAC{1'b0}}}),
    .divisor  (count),
    .busy     (div_busy_t),
    .quotient (quo_t)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_valid <= 1'b0;
    end else if (cmd.push) begin
      sched_valid <= 1'b1;
    end else if (sched_ready) begin
      sched_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      sched_data.job_id            <= res_id;
      sched_data.burst             <= res_burst;
      sched_data.wait_time         <= res_wait;
      sched_data.turnaround_time   <= res_tat;
      sched_data.avg_wait_q8       <= status.last_pass ? avg_w : '0;
      sched_data.avg_turnaround_q8 <= status.last_pass ? avg_t : '0;
      sched_data.end_of_set        <= status.last_pass;
      sched_data.dropped           <= ovf;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!sched_valid || sched_ready))
    else $error("Result pushed over a result that was not transferred.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !status.div_busy)
    else $error("Divider started while still busy.");

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_JOBS))
    else $error("Job count exceeds capacity.");

  assert property (@(posedge clk) disable iff (rst)
    cmd.swap |-> ((CNT_W'(sel) < count) && (sel >= a)))
    else $error("Selected job lies outside the unsorted part.");

endmodule

FILE: rtl/core/shortest_job_first_timing_top.sv
// Shortest-job-first scheduler. Bursts arrive on the job channel, one per
// transfer, and are numbered 1, 2, 3 in arrival order. A burst that arrives
// when MAX_JOBS jobs are held is discarded and the set is flagged as dropped.
// The transfer with last set ends the set and starts the run; job_ready stays
// low until the run has pushed its final result into the output register.
// For a set of n jobs, pass k of the selection sort reads the unsorted jobs
// through the single read port of the job memory, one per cycle. The final
// pass also runs two bit-serial dividers for the averages, one quotient bit
// per cycle.
// Results leave on the sched channel in schedule order from an output
// register. When the receiver stalls, the run continues until the next result
// is ready and then waits. Reset empties the job store and clears the flag.
module shortest_job_first_timing_top #(
  parameter int MAX_JOBS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  sjf_pkg::sjf_in_t  job_data,
  output logic              sched_valid,
  input  logic              sched_ready,
  output sjf_pkg::sjf_out_t sched_data
);

  sjf_pkg::cmd_t    cmd;
  sjf_pkg::status_t status;

  sjf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_last  (job_data.last),
    .status    (status),
    .job_ready (job_ready),
    .cmd       (cmd)
  );

  sjf_dpath #(
    .MAX_JOBS(MAX_JOBS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .job_data    (job_data),
    .sched_ready (sched_ready),
    .status      (status),
    .sched_valid (sched_valid),
    .sched_data  (sched_data)
  );

endmodule
